// File: hw/rtl/llca_pkg.sv
`timescale 1ns / 1ps

package llca_pkg;

    localparam int NUM_CORES_DEF = 16;
    localparam int CNT_W         = 16;
    localparam int MASK_W        = 16;
    localparam int ACT_W         = 5;
    localparam int CORE_W        = 8;
    localparam int STATUS_W      = 3;
    localparam int STEP_W        = 3;

    localparam logic [ACT_W-1:0]    ACTIVE_RST = 5'd16;
    localparam logic [MASK_W-1:0]   ENABLE_RST = 16'hFFFF;
    localparam logic [CNT_W-1:0]    CNT_MAX    = 16'hFFFF;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_DED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_CORES = 3'd4;

    // config register indexes
    localparam logic CFG_ACTIVE  = 1'b0;
    localparam logic CFG_ENABLED = 1'b1;

    typedef logic [STEP_W-1:0] step_t;

    // microprogram addresses
    localparam step_t STEP_IDLE     = 3'd0;
    localparam step_t STEP_DISPATCH = 3'd1;
    localparam step_t STEP_MREAD    = 3'd2;
    localparam step_t STEP_MDEC     = 3'd3;
    localparam step_t STEP_SCAN     = 3'd4;
    localparam step_t STEP_DRAIN    = 3'd5;
    localparam step_t STEP_ADEC     = 3'd6;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_START,
        COND_MANUAL,
        COND_SCAN_LAST
    } cond_sel_t;

    typedef struct packed {
        cond_sel_t cond;
        step_t     tgt;       // taken when cond holds
        step_t     nxt;       // taken otherwise
        logic      rd_scan;   // read counter at scan index, advance scan
        logic      scan_clr;  // restart scan and search
        logic      m_dec;     // manual decision, write back, emit result
        logic      a_dec;     // automatic decision, write back, emit result
    } ctrl_t;

    typedef struct packed {
        logic start;
        logic manual;
        logic scan_last;
    } cond_in_t;

endpackage

// File: hw/rtl/llca_seq.sv
`timescale 1ns / 1ps

module llca_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  llca_pkg::cond_in_t cond,
    output llca_pkg::ctrl_t   ctl,
    output logic              busy
);

    llca_pkg::step_t step_reg;
    llca_pkg::step_t step_next;
    logic            taken;

    // control store
    function automatic llca_pkg::ctrl_t rom(input llca_pkg::step_t s);
        llca_pkg::ctrl_t w;
        w = '{cond: llca_pkg::COND_ALWAYS, tgt: llca_pkg::STEP_IDLE,
              nxt: llca_pkg::STEP_IDLE, rd_scan: 1'b0, scan_clr: 1'b0,
              m_dec: 1'b0, a_dec: 1'b0};
        case (s)
            llca_pkg::STEP_IDLE:
            begin
                w.cond = llca_pkg::COND_START;
                w.tgt  = llca_pkg::STEP_DISPATCH;
                w.nxt  = llca_pkg::STEP_IDLE;
            end
            llca_pkg::STEP_DISPATCH:
            begin
                w.cond     = llca_pkg::COND_MANUAL;
                w.tgt      = llca_pkg::STEP_MREAD;
                w.nxt      = llca_pkg::STEP_SCAN;
                w.scan_clr = 1'b1;
            end
            llca_pkg::STEP_MREAD:
            begin
                w.tgt = llca_pkg::STEP_MDEC;
            end
            llca_pkg::STEP_MDEC:
            begin
                w.tgt   = llca_pkg::STEP_IDLE;
                w.m_dec = 1'b1;
            end
            llca_pkg::STEP_SCAN:
            begin
                w.cond    = llca_pkg::COND_SCAN_LAST;
                w.tgt     = llca_pkg::STEP_DRAIN;
                w.nxt     = llca_pkg::STEP_SCAN;
                w.rd_scan = 1'b1;
            end
            llca_pkg::STEP_DRAIN:
            begin
                w.tgt = llca_pkg::STEP_ADEC;
            end
            llca_pkg::STEP_ADEC:
            begin
                w.tgt   = llca_pkg::STEP_IDLE;
                w.a_dec = 1'b1;
            end
            default:
            begin
                w.tgt = llca_pkg::STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    assign ctl  = rom(step_reg);
    assign busy = (step_reg != llca_pkg::STEP_IDLE);

    always_comb
    begin
        case (ctl.cond)
            llca_pkg::COND_ALWAYS:    taken = 1'b1;
            llca_pkg::COND_START:     taken = cond.start;
            llca_pkg::COND_MANUAL:    taken = cond.manual;
            llca_pkg::COND_SCAN_LAST: taken = cond.scan_last;
            default:                  taken = 1'b1;
        endcase
        step_next = taken ? ctl.tgt : ctl.nxt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= llca_pkg::STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// File: hw/rtl/least_loaded_core_assigner.sv
`timescale 1ns / 1ps

// A manual item runs the dispatch, counter read and decision steps; an automatic item scans every core first.
// A new item is accepted only when the previous one has finished (busy low);
// the scan reads one job counter per cycle through the single counter memory port.
// done is a one-cycle strobe; the receiver cannot stall, busy falls as done rises.
// Reset (rst_n, async low): counts and dedicated marks read as zero at once
// (per-core valid bits), active_cores = 16, enabled_mask = all ones. No clearing pass.

module least_loaded_core_assigner #(
    parameter int NUM_CORES = llca_pkg::NUM_CORES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          start,
    output logic                          busy,
    input  logic                          manual_assign,
    input  logic                          share_ok,
    input  logic [llca_pkg::CORE_W-1:0]   preferred_core,
    // result channel
    output logic                          done,
    output logic [llca_pkg::STATUS_W-1:0] status,
    output logic [llca_pkg::CORE_W-1:0]   assigned_core,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [llca_pkg::MASK_W-1:0]   cfg_data
);

    localparam int IDX_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CORES - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [llca_pkg::ACT_W-1:0]  active_cores_reg;
    logic [llca_pkg::MASK_W-1:0] enabled_mask_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_cores_reg <= llca_pkg::ACTIVE_RST;
            enabled_mask_reg <= llca_pkg::ENABLE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                llca_pkg::CFG_ACTIVE:  active_cores_reg <= cfg_data[llca_pkg::ACT_W-1:0];
                llca_pkg::CFG_ENABLED: enabled_mask_reg <= cfg_data;
                default:               active_cores_reg <= active_cores_reg;
            endcase
        end
    end

    // A core is usable if it exists, is present, has an enable bit and it is set.
    function automatic logic usable(input logic [llca_pkg::CORE_W-1:0] idx);
        logic in_rng;
        in_rng = (idx < llca_pkg::CORE_W'(NUM_CORES))
              && (idx < llca_pkg::CORE_W'(active_cores_reg))
              && (idx < llca_pkg::CORE_W'(llca_pkg::MASK_W));
        return in_rng && enabled_mask_reg[idx[3:0]];
    endfunction

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    llca_pkg::ctrl_t    ctl;
    llca_pkg::cond_in_t cond;
    logic               accept;
    logic [IDX_W-1:0]   scan_idx_reg;
    logic               manual_reg;

    assign accept         = start && !busy;
    assign cond.start     = start;
    assign cond.manual    = manual_reg;
    assign cond.scan_last = (scan_idx_reg == LAST_IDX);

    llca_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .ctl   (ctl),
        .busy  (busy)
    );

    // latched request
    logic                        share_reg;
    logic [llca_pkg::CORE_W-1:0] pref_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            manual_reg <= manual_assign;
            share_reg  <= share_ok;
            pref_reg   <= preferred_core;
        end
    end

    // ------------------------------------------------------------------
    // Job count memory: one read, one write port, registered read.
    // Per-entry valid bits make unwritten entries read as zero after reset.
    // ------------------------------------------------------------------
    logic [llca_pkg::CNT_W-1:0] cnt_mem [NUM_CORES];
    logic [NUM_CORES-1:0]       cnt_vld_reg;
    logic [NUM_CORES-1:0]       ded_reg;
    logic [llca_pkg::CNT_W-1:0] rd_data_reg;
    logic                       rd_vld_reg;
    logic [llca_pkg::CNT_W-1:0] rd_cnt;
    logic [IDX_W-1:0]           rd_addr;
    logic [IDX_W-1:0]           pidx;

    logic                       wr_en;
    logic [IDX_W-1:0]           wr_idx;
    logic [llca_pkg::CNT_W-1:0] wr_cnt;
    logic                       wr_ded;

    assign pidx    = pref_reg[IDX_W-1:0];
    assign rd_addr = ctl.rd_scan ? scan_idx_reg : pidx;
    assign rd_cnt  = rd_vld_reg ? rd_data_reg : '0;

    always_ff @(posedge clk)
    begin
        rd_data_reg <= cnt_mem[rd_addr];
        if (wr_en)
        begin
            cnt_mem[wr_idx] <= wr_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_vld_reg <= '0;
            ded_reg     <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cnt_vld_reg[rd_addr];
            if (wr_en)
            begin
                cnt_vld_reg[wr_idx] <= 1'b1;
                if (wr_ded)
                begin
                    ded_reg[wr_idx] <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Scan: address stage, then compare stage in the following cycle.
    // ------------------------------------------------------------------
    logic                       cmp_vld_reg;
    logic [IDX_W-1:0]           cmp_idx_reg;
    logic                       found_reg;
    logic [IDX_W-1:0]           best_idx_reg;
    logic [llca_pkg::CNT_W-1:0] best_cnt_reg;
    logic                       better;

    // strict less-than keeps the lowest index on a tie
    assign better = cmp_vld_reg
                 && usable(llca_pkg::CORE_W'(cmp_idx_reg))
                 && !ded_reg[cmp_idx_reg]
                 && (!found_reg || (rd_cnt < best_cnt_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= ctl.rd_scan;
            if (ctl.scan_clr)
            begin
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
            end
            else
            begin
                if (ctl.rd_scan)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (better)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= scan_idx_reg;
        if (better)
        begin
            best_idx_reg <= cmp_idx_reg;
            best_cnt_reg <= rd_cnt;
        end
    end

    // ------------------------------------------------------------------
    // Decision and write-back
    // ------------------------------------------------------------------
    logic [llca_pkg::STATUS_W-1:0] status_next;
    logic [llca_pkg::CORE_W-1:0]   core_next;
    logic [llca_pkg::CNT_W-1:0]    base_cnt;

    always_comb
    begin
        status_next = llca_pkg::ST_OK;
        core_next   = pref_reg;
        wr_en       = 1'b0;
        wr_idx      = pidx;
        base_cnt    = rd_cnt;
        if (ctl.m_dec)
        begin
            if (!usable(pref_reg))
            begin
                status_next = llca_pkg::ST_RANGE;
            end
            else if (ded_reg[pidx])
            begin
                status_next = llca_pkg::ST_BUSY;
            end
            else if (!share_reg && (rd_cnt != '0))
            begin
                status_next = llca_pkg::ST_NO_DED;
            end
            else
            begin
                wr_en = 1'b1;
            end
        end
        else if (ctl.a_dec)
        begin
            wr_idx   = best_idx_reg;
            base_cnt = best_cnt_reg;
            if (!found_reg)
            begin
                status_next = llca_pkg::ST_NO_CORES;
            end
            else
            begin
                core_next = llca_pkg::CORE_W'(best_idx_reg);
                if (!share_reg && (best_cnt_reg != '0))
                begin
                    status_next = llca_pkg::ST_NO_DED;
                end
                else
                begin
                    wr_en = 1'b1;
                end
            end
        end
        // saturating increment
        wr_cnt = (base_cnt == llca_pkg::CNT_MAX) ? base_cnt : base_cnt + 1'b1;
        wr_ded = !share_reg;
    end

    // result register
    logic                          done_reg;
    logic [llca_pkg::STATUS_W-1:0] status_reg;
    logic [llca_pkg::CORE_W-1:0]   core_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.m_dec || ctl.a_dec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.m_dec || ctl.a_dec)
        begin
            status_reg <= status_next;
            core_reg   <= core_next;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign assigned_core = core_reg;

`ifndef ASSERT_OFF
    // a result only follows a busy cycle (the decision step)
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a decision step");

    // an accepted item always occupies the sequencer
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start the sequencer");

    // a granted core was usable, hence inside the core range
    a_ok_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == llca_pkg::ST_OK))
            |-> (assigned_core < llca_pkg::CORE_W'(NUM_CORES)))
        else $error("granted core out of range");

    // a counter write never lands while the scan is reading
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !ctl.rd_scan)
        else $error("write during scan");
`endif

endmodule

// File: tb/sv/llca_checker.sv
`timescale 1ns / 1ps

module llca_checker #(
    parameter int NUM_CORES = llca_pkg::NUM_CORES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          manual_assign,
    input  logic                          share_ok,
    input  logic [llca_pkg::CORE_W-1:0]   preferred_core,
    input  logic                          done,
    input  logic [llca_pkg::STATUS_W-1:0] status,
    input  logic [llca_pkg::CORE_W-1:0]   assigned_core,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [llca_pkg::MASK_W-1:0]   cfg_data,
    output int                            fail_count,
    output int                            pending
);
    import llca_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CORE_W-1:0]   core;
    } placement_t;

    // shadow of the block's table and registers
    logic [CNT_W-1:0]  job_count [NUM_CORES];
    logic              dedicated [NUM_CORES];
    logic [ACT_W-1:0]  active_cores;
    logic [MASK_W-1:0] enabled_mask;

    placement_t placement_q[$];
    int         n_fail;

    function automatic logic core_usable(input int i);
        if (i >= NUM_CORES || i >= int'(active_cores) || i >= MASK_W)
            return 1'b0;
        return enabled_mask[i];
    endfunction

    task automatic bump_count(input int i);
        if (job_count[i] != CNT_MAX)
            job_count[i] = job_count[i] + 1'b1;
    endtask

    // work out the result of one request and update the shadow table
    task automatic predict_placement(input logic manual, input logic share,
                                     input logic [CORE_W-1:0] pref);
        placement_t res;
        logic       found;
        int         best;
        res.status = ST_OK;
        res.core   = pref;
        found      = 1'b0;
        best       = 0;
        if (manual) begin
            if (!core_usable(int'(pref)))
                res.status = ST_RANGE;
            else if (dedicated[pref])
                res.status = ST_BUSY;
            else if (!share && job_count[pref] != '0)
                res.status = ST_NO_DED;
            else
            begin
                if (!share)
                    dedicated[pref] = 1'b1;
                bump_count(int'(pref));
            end
        end
        else
        begin
            for (int i = 0; i < NUM_CORES; i++)
            begin
                if (core_usable(i) && !dedicated[i])
                begin
                    if (!found || job_count[i] < job_count[best])
                    begin
                        best  = i;
                        found = 1'b1;
                    end
                end
            end
            if (!found)
                res.status = ST_NO_CORES;
            else
            begin
                res.core = CORE_W'(best);
                if (!share && job_count[best] != '0)
                    res.status = ST_NO_DED;
                else
                begin
                    if (!share)
                        dedicated[best] = 1'b1;
                    bump_count(best);
                end
            end
        end
        placement_q.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CORES; i++)
            begin
                job_count[i] = '0;
                dedicated[i] = 1'b0;
            end
            active_cores = ACTIVE_RST;
            enabled_mask = ENABLE_RST;
            placement_q.delete();
            n_fail     = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ACTIVE:  active_cores = cfg_data[ACT_W-1:0];
                    CFG_ENABLED: enabled_mask = cfg_data;
                    default: ;
                endcase
            end
            // the result leaving on this edge belongs to an older item than
            // one accepted on the same edge, so compare first
            if (done)
            begin
                if (placement_q.size() == 0)
                begin
                    $error("unexpected result: status %0d core %0d", status, assigned_core);
                    n_fail++;
                end
                else
                begin
                    placement_t want;
                    want = placement_q.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        n_fail++;
                    end
                    if (assigned_core !== want.core)
                    begin
                        $error("assigned_core: expected %0d, got %0d",
                               want.core, assigned_core);
                        n_fail++;
                    end
                end
            end
            if (start && !busy)
                predict_placement(manual_assign, share_ok, preferred_core);
            fail_count <= n_fail;
            pending    <= placement_q.size();
        end
    end

endmodule

// File: tb/sv/tb_least_loaded_core_assigner.sv
`timescale 1ns / 1ps

module tb_least_loaded_core_assigner;
    import llca_pkg::*;

    localparam int NUM_CORES   = NUM_CORES_DEF;
    // automatic items scan every core, so this covers the longest item easily
    localparam int SETTLE      = NUM_CORES + 8;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_ITEMS = 100;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                manual_assign;
    logic                share_ok;
    logic [CORE_W-1:0]   preferred_core;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [CORE_W-1:0]   assigned_core;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_index;
    logic [MASK_W-1:0]   cfg_data;

    int fail_count;
    int pending;
    int stall_cycles;
    int gap_pct;    // chance in percent that the sender sits out a cycle

    least_loaded_core_assigner #(
        .NUM_CORES(NUM_CORES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .manual_assign (manual_assign),
        .share_ok      (share_ok),
        .preferred_core(preferred_core),
        .done          (done),
        .status        (status),
        .assigned_core (assigned_core),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    llca_checker #(
        .NUM_CORES(NUM_CORES)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .manual_assign (manual_assign),
        .share_ok      (share_ok),
        .preferred_core(preferred_core),
        .done          (done),
        .status        (status),
        .assigned_core (assigned_core),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: any handshake or result clears the count of dead cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stall_cycles <= 0;
        else if ((start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // All driving happens at the falling edge; the block samples at the rising
    // edge. Called and returning at a falling edge. start stays high on return
    // so back-to-back items need no low pulse in between.
    task automatic send_item(input logic m, input logic s, input logic [CORE_W-1:0] p);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start          = 1'b1;
        manual_assign  = m;
        share_ok       = s;
        preferred_core = p;
        #1;
        while (busy)
        begin
            @(negedge clk);
            #1;
        end
        @(negedge clk);     // the rising edge in between took the item
    endtask

    // Wait until every placement has come back, plus some quiet cycles.
    task automatic drain_results();
        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [MASK_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        #1;
        while (!cfg_ready)
        begin
            @(negedge clk);
            #1;
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Random request. Dedicated requests are kept rare: marks are never
    // released, and once most cores are reserved every request just bounces.
    task automatic random_request();
        logic [CORE_W-1:0] p;
        if ($urandom_range(0, 9) == 0)
            p = CORE_W'($urandom_range(0, 255));
        else
            p = CORE_W'($urandom_range(0, NUM_CORES + 1));
        send_item(1'($urandom_range(0, 1)), $urandom_range(0, 99) >= 10, p);
    endtask

    initial
    begin : stimulus
        int gap_tab [4];
        gap_tab = '{0, 50, 0, 36};

        rst_n          = 1'b0;
        start          = 1'b0;
        manual_assign  = 1'b0;
        share_ok       = 1'b0;
        preferred_core = '0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_ACTIVE;
        cfg_data       = '0;
        gap_pct        = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ---- directed part, reset settings ----
        // first item goes to core 0, so core 0 can never become dedicated
        send_item(1'b0, 1'b1, 8'd0);    // auto shared, all counts zero -> core 0
        send_item(1'b1, 1'b1, 8'd0);    // manual shared
        send_item(1'b1, 1'b0, 8'd0);    // manual dedicated on a loaded core
        send_item(1'b1, 1'b0, 8'd15);   // manual dedicated, top core, granted
        send_item(1'b1, 1'b1, 8'd15);   // shared on a dedicated core -> busy
        send_item(1'b1, 1'b0, 8'd15);   // dedicated again -> busy
        send_item(1'b1, 1'b1, 8'd16);   // first index past the core count
        send_item(1'b1, 1'b1, 8'd255);  // largest index
        send_item(1'b0, 1'b0, 8'd0);    // auto dedicated, idle core exists
        send_item(1'b0, 1'b1, 8'hAA);   // auto shared, tie broken low
        send_item(1'b1, 1'b1, 8'h55);

        // only core 0 enabled
        drain_results();
        write_reg(CFG_ENABLED, 16'h0001);
        send_item(1'b1, 1'b1, 8'd3);    // disabled core
        send_item(1'b0, 1'b0, 8'd7);    // lowest count is nonzero -> no dedicated
        send_item(1'b0, 1'b1, 8'd7);

        // nothing enabled
        drain_results();
        write_reg(CFG_ENABLED, 16'h0000);
        send_item(1'b0, 1'b1, 8'h5A);   // no cores; preferred index echoed
        send_item(1'b1, 1'b1, 8'd0);

        // active_cores of zero: no core is valid even with all enabled
        drain_results();
        write_reg(CFG_ENABLED, 16'hFFFF);
        write_reg(CFG_ACTIVE, 16'd0);
        send_item(1'b0, 1'b1, 8'hA5);
        send_item(1'b1, 1'b1, 8'd0);

        // active_cores above NUM_CORES: the core count still bounds the range
        drain_results();
        write_reg(CFG_ACTIVE, 16'd31);
        send_item(1'b1, 1'b1, 8'd16);
        send_item(1'b1, 1'b1, 8'd5);

        // a single core present
        drain_results();
        write_reg(CFG_ACTIVE, 16'd1);
        send_item(1'b0, 1'b1, 8'd9);
        send_item(1'b1, 1'b1, 8'd1);

        // ---- random part, one register setting per phase ----
        for (int ph = 0; ph < 4; ph++)
        begin
            drain_results();
            case (ph)
                0:
                begin
                    write_reg(CFG_ACTIVE, MASK_W'(ACTIVE_RST));
                    write_reg(CFG_ENABLED, ENABLE_RST);
                end
                1:
                begin
                    // upper data bits are don't-care for the core count
                    write_reg(CFG_ACTIVE, {11'($urandom), 5'($urandom_range(1, 16))});
                    write_reg(CFG_ENABLED, 16'($urandom));
                end
                2:
                begin
                    write_reg(CFG_ACTIVE, MASK_W'(ACTIVE_RST));
                    write_reg(CFG_ENABLED, 16'($urandom) | 16'($urandom));
                end
                default:
                begin
                    write_reg(CFG_ACTIVE, {11'($urandom), 5'($urandom_range(0, 31))});
                    write_reg(CFG_ENABLED, 16'($urandom));
                end
            endcase
            gap_pct = gap_tab[ph];
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_request();
        end

        drain_results();
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
